[sv/dscw_pkg.sv]
// Package for the DDS serial command writer: action codes, register addresses,
// the frequency divider constants and the microcode ROM.
// No dependencies.
`default_nettype none

package dscw_pkg;

  localparam int unsigned STEP_W = 4;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned SH_W   = 40;

  localparam logic [1:0] ACT_FREQ  = 2'd0;
  localparam logic [1:0] ACT_PHASE = 2'd1;
  localparam logic [1:0] ACT_AMP   = 2'd2;
  localparam logic [1:0] ACT_RAW   = 2'd3;

  localparam logic [6:0] REG_CSR   = 7'h00;
  localparam logic [6:0] REG_CFTW0 = 7'h04;
  localparam logic [6:0] REG_CPOW0 = 7'h05;
  localparam logic [6:0] REG_ACR   = 7'h06;

  localparam logic [27:0] FREQ_LIMIT = 28'd250000000;
  // 500 MHz = 2^8 * 1953125, so ftw = floor(f * 2^24 / 1953125)
  localparam logic [20:0] DIV_CONST  = 21'd1953125;
  // floor(2^52 / 1953125); (f * DIV_RECIP) >> 28 is low by at most one
  localparam logic [31:0] DIV_RECIP  = 32'd2305843009;

  typedef enum logic [3:0] {
    OP_WAIT,
    OP_CHECK,
    OP_LOAD_CSR,
    OP_SEND,
    OP_DISPATCH,
    OP_DIV_INIT,
    OP_DIV_MUL,
    OP_DIV_FIX,
    OP_LOAD_FTW,
    OP_LOAD_RAW,
    OP_LOAD_POW,
    OP_LOAD_ACR
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [STEP_W-1:0] jmp;
    logic             fin;
  } ctl_word_t;

  localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] STEP_CHECK    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_SEND_CSR = 4'd3;
  localparam logic [STEP_W-1:0] STEP_DIV_INIT = 4'd5;
  localparam logic [STEP_W-1:0] STEP_RAW      = 4'd9;
  localparam logic [STEP_W-1:0] STEP_POW      = 4'd10;
  localparam logic [STEP_W-1:0] STEP_SEND_FIN = 4'd12;

  function automatic ctl_word_t dscw_rom(input logic [STEP_W-1:0] step);
    ctl_word_t w;
    unique case (step)
      4'd0:    w = '{op: OP_WAIT,     jmp: STEP_CHECK,    fin: 1'b0};
      4'd1:    w = '{op: OP_CHECK,    jmp: STEP_RAW,      fin: 1'b0};
      4'd2:    w = '{op: OP_LOAD_CSR, jmp: STEP_SEND_CSR, fin: 1'b0};
      4'd3:    w = '{op: OP_SEND,     jmp: 4'd4,          fin: 1'b0};
      4'd4:    w = '{op: OP_DISPATCH, jmp: STEP_POW,      fin: 1'b0};
      4'd5:    w = '{op: OP_DIV_INIT, jmp: 4'd6,          fin: 1'b0};
      4'd6:    w = '{op: OP_DIV_MUL,  jmp: 4'd7,          fin: 1'b0};
      4'd7:    w = '{op: OP_DIV_FIX,  jmp: 4'd8,          fin: 1'b0};
      4'd8:    w = '{op: OP_LOAD_FTW, jmp: STEP_SEND_FIN, fin: 1'b0};
      4'd9:    w = '{op: OP_LOAD_RAW, jmp: STEP_SEND_FIN, fin: 1'b0};
      4'd10:   w = '{op: OP_LOAD_POW, jmp: STEP_SEND_FIN, fin: 1'b0};
      4'd11:   w = '{op: OP_LOAD_ACR, jmp: STEP_SEND_FIN, fin: 1'b0};
      4'd12:   w = '{op: OP_SEND,     jmp: STEP_IDLE,     fin: 1'b1};
      default: w = '{op: OP_WAIT,     jmp: STEP_CHECK,    fin: 1'b0};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] chan_sel(input logic [1:0] ch);
    logic [7:0] s;
    unique case (ch)
      2'd0:    s = 8'h10;
      2'd1:    s = 8'h20;
      2'd2:    s = 8'h40;
      default: s = 8'h80;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[sv/dds_serial_command_writer_core.sv]
// Serial command writer for a four-channel DDS: one command in, a run of
// MSB-first bits out, driven by a microcode ROM from dscw_pkg.
// Commands are raw register writes and phase, amplitude and frequency writes;
// a non-raw command with a bad channel is dropped. The shifter sends one bit
// per cycle while the output is not stalled, and a frequency write adds a
// three-step reciprocal multiply for the tuning word. Next command is taken once
// the run is queued.
// Reset (rst_ni low, asynchronous) returns the sequencer to its wait step.
`default_nettype none

module dds_serial_command_writer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  // channel[2:0], value[30:3], reg_address[37:31], write_data[69:38],
  // byte_count[72:70], zero fill
  input  wire logic [79:0] s_axis_tdata_i,
  // action[1:0]
  input  wire logic [1:0]  s_axis_tuser_i,
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // serial_data[0], zero fill
  output      logic [7:0]  m_axis_tdata_o,
  // frame_end[0]
  output      logic        m_axis_tuser_o,
  output      logic        m_axis_tlast_o
);

  logic [dscw_pkg::STEP_W-1:0] step_q, step_d;
  logic [dscw_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [dscw_pkg::SH_W-1:0]   sh_q, sh_d;
  logic [1:0]  act_q, act_d;
  logic [2:0]  chan_q, chan_d;
  logic [27:0] val_q, val_d;
  logic [6:0]  addr_q, addr_d;
  logic [31:0] wd_q, wd_d;
  logic [2:0]  bc_q, bc_d;
  logic [27:0] dvd_q, dvd_d;
  logic [21:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic        m_valid_q, m_valid_d;
  logic        m_data_q, m_data_d;
  logic        m_fe_q, m_fe_d;
  logic        m_last_q, m_last_d;

  dscw_pkg::ctl_word_t ctl;
  logic        out_free;
  logic [59:0] est_prod;
  logic [21:0] fix_prod;
  logic [31:0] raw_data;
  logic [dscw_pkg::CNT_W-1:0] raw_cnt;

  assign ctl             = dscw_pkg::dscw_rom(step_q);
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (ctl.op == dscw_pkg::OP_WAIT);
  assign est_prod        = dvd_q * dscw_pkg::DIV_RECIP;
  assign fix_prod        = quo_q[21:0] * {1'b0, dscw_pkg::DIV_CONST};

  always_comb begin
    unique case (bc_q)
      3'd0: begin
        raw_data = 32'h0;
        raw_cnt  = 6'd8;
      end
      3'd1: begin
        raw_data = {wd_q[7:0], 24'h0};
        raw_cnt  = 6'd16;
      end
      3'd2: begin
        raw_data = {wd_q[15:0], 16'h0};
        raw_cnt  = 6'd24;
      end
      3'd3: begin
        raw_data = {wd_q[23:0], 8'h0};
        raw_cnt  = 6'd32;
      end
      default: begin
        raw_data = wd_q;
        raw_cnt  = 6'd40;
      end
    endcase
  end

  always_comb begin
    step_d    = step_q;
    cnt_d     = cnt_q;
    sh_d      = sh_q;
    act_d     = act_q;
    chan_d    = chan_q;
    val_d     = val_q;
    addr_d    = addr_q;
    wd_d      = wd_q;
    bc_d      = bc_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    m_fe_d    = m_fe_q;
    m_last_d  = m_last_q;
    unique case (ctl.op)
      dscw_pkg::OP_WAIT: begin
        if (s_axis_tvalid_i) begin
          act_d  = s_axis_tuser_i;
          chan_d = s_axis_tdata_i[2:0];
          val_d  = s_axis_tdata_i[30:3];
          addr_d = s_axis_tdata_i[37:31];
          wd_d   = s_axis_tdata_i[69:38];
          bc_d   = s_axis_tdata_i[72:70];
          step_d = ctl.jmp;
        end
      end
      dscw_pkg::OP_CHECK: begin
        priority if (act_q == dscw_pkg::ACT_RAW) begin
          step_d = ctl.jmp;
        end else if (chan_q[2]) begin
          step_d = dscw_pkg::STEP_IDLE;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      dscw_pkg::OP_LOAD_CSR: begin
        sh_d   = {1'b0, dscw_pkg::REG_CSR, dscw_pkg::chan_sel(chan_q[1:0]), 24'h0};
        cnt_d  = 6'd16;
        step_d = ctl.jmp;
      end
      dscw_pkg::OP_SEND: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = sh_q[dscw_pkg::SH_W-1];
          m_fe_d    = (cnt_q == 6'd1);
          m_last_d  = (cnt_q == 6'd1) && ctl.fin;
          sh_d      = {sh_q[dscw_pkg::SH_W-2:0], 1'b0};
          cnt_d     = cnt_q - 6'd1;
          if (cnt_q == 6'd1) begin
            step_d = ctl.jmp;
          end
        end
      end
      dscw_pkg::OP_DISPATCH: begin
        priority if (act_q == dscw_pkg::ACT_FREQ) begin
          step_d = dscw_pkg::STEP_DIV_INIT;
        end else if (act_q == dscw_pkg::ACT_PHASE) begin
          step_d = ctl.jmp;
        end else begin
          step_d = ctl.jmp + 4'd1;
        end
      end
      dscw_pkg::OP_DIV_INIT: begin
        dvd_d  = (val_q > dscw_pkg::FREQ_LIMIT) ? dscw_pkg::FREQ_LIMIT : val_q;
        rem_d  = '0;
        quo_d  = '0;
        step_d = ctl.jmp;
      end
      dscw_pkg::OP_DIV_MUL: begin
        quo_d  = est_prod[59:28];
        step_d = ctl.jmp;
      end
      dscw_pkg::OP_DIV_FIX: begin
        rem_d  = 22'd0 - fix_prod;
        step_d = ctl.jmp;
      end
      dscw_pkg::OP_LOAD_FTW: begin
        sh_d   = {1'b0, dscw_pkg::REG_CFTW0,
                  quo_q + {31'd0, (rem_q >= {1'b0, dscw_pkg::DIV_CONST})}};
        cnt_d  = 6'd40;
        step_d = ctl.jmp;
      end
      dscw_pkg::OP_LOAD_RAW: begin
        sh_d   = {1'b0, addr_q, raw_data};
        cnt_d  = raw_cnt;
        step_d = ctl.jmp;
      end
      dscw_pkg::OP_LOAD_POW: begin
        sh_d   = {1'b0, dscw_pkg::REG_CPOW0, val_q[15:0], 16'h0};
        cnt_d  = 6'd24;
        step_d = ctl.jmp;
      end
      dscw_pkg::OP_LOAD_ACR: begin
        sh_d   = {1'b0, dscw_pkg::REG_ACR, 8'h00, 6'b000101, val_q[9:0], 8'h0};
        cnt_d  = 6'd32;
        step_d = ctl.jmp;
      end
      default: begin
        step_d = dscw_pkg::STEP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= dscw_pkg::STEP_IDLE;
      cnt_q     <= '0;
      sh_q      <= '0;
      act_q     <= '0;
      chan_q    <= '0;
      val_q     <= '0;
      addr_q    <= '0;
      wd_q      <= '0;
      bc_q      <= '0;
      dvd_q     <= '0;
      rem_q     <= '0;
      quo_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= 1'b0;
      m_fe_q    <= 1'b0;
      m_last_q  <= 1'b0;
    end else begin
      step_q    <= step_d;
      cnt_q     <= cnt_d;
      sh_q      <= sh_d;
      act_q     <= act_d;
      chan_q    <= chan_d;
      val_q     <= val_d;
      addr_q    <= addr_d;
      wd_q      <= wd_d;
      bc_q      <= bc_d;
      dvd_q     <= dvd_d;
      rem_q     <= rem_d;
      quo_q     <= quo_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      m_fe_q    <= m_fe_d;
      m_last_q  <= m_last_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {7'h0, m_data_q};
  assign m_axis_tuser_o  = m_fe_q;
  assign m_axis_tlast_o  = m_last_q;

  a_last_ends_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o)
    else $error("tlast without frame end");

  a_rem_below_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.op == dscw_pkg::OP_LOAD_FTW |-> rem_q < {dscw_pkg::DIV_CONST, 1'b0})
    else $error("divider remainder out of range");

  a_accept_to_check : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> step_q == dscw_pkg::STEP_CHECK)
    else $error("sequencer missed accepted command");

  a_send_has_bits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.op == dscw_pkg::OP_SEND |-> cnt_q != '0)
    else $error("send step with empty shifter");

endmodule

`default_nettype wire
